// File: rtl/obso_pkg.sv
// ----------------------------------------------------------------------------
// obso_pkg
// Shared types and constants of the oriented box / sphere overlap block.
// ----------------------------------------------------------------------------
package obso_pkg;

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER,
    REG_AXIS_U,
    REG_AXIS_V,
    REG_AXIS_W,
    REG_HALF
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_INSIDE,
    CLS_FACE,
    CLS_CORNER
  } cls_t;

  typedef struct packed {
    logic [CFG_W-1:0] center;
    logic [CFG_W-1:0] axis_u;
    logic [CFG_W-1:0] axis_v;
    logic [CFG_W-1:0] axis_w;
    logic [CFG_W-1:0] half_sizes;
  } box_t;

endpackage

// File: rtl/obso_in_if.sv
// ----------------------------------------------------------------------------
// obso_in_if
// Sphere channel: valid/ready handshake with centre and radius.
// ----------------------------------------------------------------------------
interface obso_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sphere_x;
  logic signed [COORD_BITS-1:0] sphere_y;
  logic signed [COORD_BITS-1:0] sphere_z;
  logic        [COORD_BITS-1:0] sphere_radius;

  modport source (
    output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
    input  ready
  );

  modport sink (
    input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
    output ready
  );
endinterface

// File: rtl/obso_out_if.sv
// ----------------------------------------------------------------------------
// obso_out_if
// Result channel: valid/ready handshake with the hit flag.
// ----------------------------------------------------------------------------
interface obso_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

// File: rtl/obso_project.sv
// ----------------------------------------------------------------------------
// obso_project
// Stages 1-3: centre offset, axis products, absolute projections.
// ----------------------------------------------------------------------------
module obso_project #(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic [2:0]                             ld,
  input  obso_pkg::box_t                         box,
  input  logic signed [COORD_BITS-1:0]           sphere_x,
  input  logic signed [COORD_BITS-1:0]           sphere_y,
  input  logic signed [COORD_BITS-1:0]           sphere_z,
  input  logic        [COORD_BITS-1:0]           sphere_radius,
  output logic [2:0][COORD_BITS+16:0]            proj,
  output logic        [COORD_BITS-1:0]           rad,
  output logic        [2*COORD_BITS-1:0]         rad_sq
);

  localparam int C   = COORD_BITS;
  localparam int EXT = (3 * C > obso_pkg::CFG_W) ? 3 * C : obso_pkg::CFG_W;
  localparam int DW  = C + 1;
  localparam int PW  = C + obso_pkg::AXIS_W + 1;
  localparam int SW  = PW + 1;
  localparam int AW  = C + 17;

  logic [EXT-1:0]                          cen_ext;
  logic signed [C-1:0]                     cen [3];
  logic signed [C-1:0]                     sph [3];
  logic [2:0][2:0][obso_pkg::AXIS_W-1:0]   ax;
  logic signed [SW-1:0]                    psum [3];

  logic signed [DW-1:0]                    diff_r [3];
  logic signed [PW-1:0]                    prod_r [3][3];
  logic [2:0][AW-1:0]                      proj_r;
  logic [C-1:0]                            rad1_r, rad2_r, rad3_r;
  logic [2*C-1:0]                          rsq2_r, rsq3_r;

  always_comb begin
    cen_ext = EXT'(box.center);
    for (int k = 0; k < 3; k++) begin
      cen[k] = cen_ext[k*C +: C];
    end
    sph[0] = sphere_x;
    sph[1] = sphere_y;
    sph[2] = sphere_z;
    ax[0]  = box.axis_u;
    ax[1]  = box.axis_v;
    ax[2]  = box.axis_w;
    for (int j = 0; j < 3; j++) begin
      psum[j] = SW'(prod_r[j][0]) + SW'(prod_r[j][1]) + SW'(prod_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < 3; k++) begin
        diff_r[k] <= DW'(sph[k]) - DW'(cen[k]);
      end
      rad1_r <= sphere_radius;
    end
    if (ld[1]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[j][k] <= PW'(diff_r[k]) * PW'($signed(ax[j][k]));
        end
      end
      rad2_r <= rad1_r;
      rsq2_r <= (2*C)'(rad1_r) * (2*C)'(rad1_r);
    end
    if (ld[2]) begin
      for (int j = 0; j < 3; j++) begin
        proj_r[j] <= AW'(psum[j][SW-1] ? -psum[j] : psum[j]);
      end
      rad3_r <= rad2_r;
      rsq3_r <= rsq2_r;
    end
  end

  assign proj   = proj_r;
  assign rad    = rad3_r;
  assign rad_sq = rsq3_r;

endmodule

// File: rtl/obso_classify.sv
// ----------------------------------------------------------------------------
// obso_classify
// Stage 4: compare projections with half extents, region class and excess.
// ----------------------------------------------------------------------------
module obso_classify #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           ld,
  input  obso_pkg::box_t                 box,
  input  logic [2:0][COORD_BITS+16:0]    proj,
  input  logic [COORD_BITS-1:0]          rad,
  input  logic [2*COORD_BITS-1:0]        rad_sq,
  output logic [2:0][COORD_BITS+16:0]    excess,
  output obso_pkg::cls_t                 cls,
  output logic [COORD_BITS-1:0]          rad_o,
  output logic [2*COORD_BITS-1:0]        rad_sq_o
);

  localparam int C   = COORD_BITS;
  localparam int EXT = (3 * C > obso_pkg::CFG_W) ? 3 * C : obso_pkg::CFG_W;
  localparam int AW  = C + 17;

  logic [EXT-1:0]     half_ext;
  logic [2:0][AW-1:0] ext;
  logic [2:0][AW-1:0] d;
  logic [2:0]         outside;
  obso_pkg::cls_t     cls_nxt;

  logic [2:0][AW-1:0] dist_r;
  obso_pkg::cls_t     cls_r;
  logic [C-1:0]       rad_r;
  logic [2*C-1:0]     rsq_r;

  always_comb begin
    half_ext = EXT'(box.half_sizes);
    for (int j = 0; j < 3; j++) begin
      ext[j]     = AW'({half_ext[j*C +: C], {obso_pkg::AXIS_FRAC{1'b0}}});
      outside[j] = proj[j] > ext[j];
      d[j]       = outside[j] ? proj[j] - ext[j] : '0;
    end
    case ($countones(outside))
      0:       cls_nxt = obso_pkg::CLS_INSIDE;
      1:       cls_nxt = obso_pkg::CLS_FACE;
      default: cls_nxt = obso_pkg::CLS_CORNER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dist_r <= d;
      cls_r  <= cls_nxt;
      rad_r  <= rad;
      rsq_r  <= rad_sq;
    end
  end

  assign excess   = dist_r;
  assign cls      = cls_r;
  assign rad_o    = rad_r;
  assign rad_sq_o = rsq_r;

endmodule

// File: rtl/obso_distance.sv
// ----------------------------------------------------------------------------
// obso_distance
// Stages 5-7: face test, split squares, squared distance against radius.
// ----------------------------------------------------------------------------
module obso_distance #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic [2:0]                     ld,
  input  logic [2:0][COORD_BITS+16:0]    excess,
  input  obso_pkg::cls_t                 cls,
  input  logic [COORD_BITS-1:0]          rad,
  input  logic [2*COORD_BITS-1:0]        rad_sq,
  output logic                           hit
);

  localparam int C   = COORD_BITS;
  localparam int AW  = C + 17;
  localparam int HW  = (AW + 1) / 2;
  localparam int PPW = 2 * HW;
  localparam int XW  = 2 * PPW;
  localparam int SQW = 2 * AW;
  localparam int TW  = SQW + 2;
  localparam int FW  = AW + 2;

  logic [2:0][HW-1:0]  lo, hi;
  logic [FW-1:0]       face_sum, face_lim;
  logic [2:0][XW-1:0]  sq_full;
  logic [TW-1:0]       tot, rlim;
  logic                hit_nxt;

  logic [2:0][PPW-1:0] ll_r, lh_r, hh_r;
  logic                fh5_r, fh6_r;
  obso_pkg::cls_t      cls5_r, cls6_r;
  logic [2*C-1:0]      rsq5_r, rsq6_r;
  logic [2:0][SQW-1:0] sq6_r;
  logic                hit_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo[j] = excess[j][HW-1:0];
      hi[j] = HW'(excess[j][AW-1:HW]);
    end
    face_sum = FW'(excess[0]) + FW'(excess[1]) + FW'(excess[2]);
    face_lim = FW'({rad, {obso_pkg::AXIS_FRAC{1'b0}}});
    for (int j = 0; j < 3; j++) begin
      sq_full[j] = (XW'(hh_r[j]) << (2 * HW)) + (XW'(lh_r[j]) << (HW + 1))
                 + XW'(ll_r[j]);
    end
    tot  = TW'(sq6_r[0]) + TW'(sq6_r[1]) + TW'(sq6_r[2]);
    rlim = TW'({rsq6_r, {(2 * obso_pkg::AXIS_FRAC){1'b0}}});
    case (cls6_r)
      obso_pkg::CLS_INSIDE: hit_nxt = 1'b1;
      obso_pkg::CLS_FACE:   hit_nxt = fh6_r;
      default:              hit_nxt = tot <= rlim;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int j = 0; j < 3; j++) begin
        ll_r[j] <= PPW'(lo[j]) * PPW'(lo[j]);
        lh_r[j] <= PPW'(lo[j]) * PPW'(hi[j]);
        hh_r[j] <= PPW'(hi[j]) * PPW'(hi[j]);
      end
      fh5_r  <= face_sum <= face_lim;
      cls5_r <= cls;
      rsq5_r <= rad_sq;
    end
    if (ld[1]) begin
      for (int j = 0; j < 3; j++) begin
        sq6_r[j] <= SQW'(sq_full[j]);
      end
      fh6_r  <= fh5_r;
      cls6_r <= cls5_r;
      rsq6_r <= rsq5_r;
    end
    if (ld[2]) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// File: rtl/oriented_box_sphere_overlap.sv
// ----------------------------------------------------------------------------
// oriented_box_sphere_overlap
// Sphere against oriented box overlap test, one sphere per cycle while out_word is ready.
// ----------------------------------------------------------------------------
// Usage:
//   Load the box through the cfg port (cfg_we, cfg_idx, cfg_data): centre,
//   three axes and half extents, one 48-bit register per write. Write only
//   while no sphere is in flight; indexes beyond the list are ignored.
//   Spheres arrive on in_word (valid/ready); one hit word leaves on
//   out_word for each sphere, in order.
//   From acceptance to out_word.valid a sphere passes the seven register
//   stages: offset, axis products, projection, region class, split squares,
//   square sum, result. Throughput is one word per cycle while out_word is ready.
//   When the receiver stalls, the result stays in the output stage and
//   earlier stages keep filling until every stage holds a word; only then
//   does in_word.ready drop. Empty stages close up while stalled.
//   Reset clears every stage and all box registers; with a zero box every
//   sphere reports a hit.
// ----------------------------------------------------------------------------
module oriented_box_sphere_overlap #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  obso_in_if.sink                        in_word,
  obso_out_if.source                     out_word,
  input  logic                           cfg_we,
  input  logic [obso_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [obso_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NST = 7;
  localparam int C   = COORD_BITS;
  localparam int AW  = C + 17;

  obso_pkg::box_t     box_r;
  logic [NST:1]       v_r, v_nxt, v_prev, ld;
  logic [NST+1:1]     rdy;

  logic [2:0][AW-1:0] proj, excess;
  logic [C-1:0]       rad3, rad4;
  logic [2*C-1:0]     rsq3, rsq4;
  obso_pkg::cls_t     cls4;
  logic               hit;

  always_comb begin
    rdy[NST+1] = out_word.ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_prev = {v_r[NST-1:1], in_word.valid};
    ld     = rdy[NST:1] & v_prev;
    v_nxt  = (rdy[NST:1] & v_prev) | (~rdy[NST:1] & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      box_r <= '0;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        case (obso_pkg::reg_idx_t'(cfg_idx))
          obso_pkg::REG_CENTER: box_r.center     <= cfg_data;
          obso_pkg::REG_AXIS_U: box_r.axis_u     <= cfg_data;
          obso_pkg::REG_AXIS_V: box_r.axis_v     <= cfg_data;
          obso_pkg::REG_AXIS_W: box_r.axis_w     <= cfg_data;
          obso_pkg::REG_HALF:   box_r.half_sizes <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  obso_project #(.COORD_BITS(COORD_BITS)) u_project (
    .clk           (clk),
    .ld            (ld[3:1]),
    .box           (box_r),
    .sphere_x      (in_word.sphere_x),
    .sphere_y      (in_word.sphere_y),
    .sphere_z      (in_word.sphere_z),
    .sphere_radius (in_word.sphere_radius),
    .proj          (proj),
    .rad           (rad3),
    .rad_sq        (rsq3)
  );

  obso_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .clk      (clk),
    .ld       (ld[4]),
    .box      (box_r),
    .proj     (proj),
    .rad      (rad3),
    .rad_sq   (rsq3),
    .excess   (excess),
    .cls      (cls4),
    .rad_o    (rad4),
    .rad_sq_o (rsq4)
  );

  obso_distance #(.COORD_BITS(COORD_BITS)) u_distance (
    .clk    (clk),
    .ld     (ld[7:5]),
    .excess (excess),
    .cls    (cls4),
    .rad    (rad4),
    .rad_sq (rsq4),
    .hit    (hit)
  );

  assign in_word.ready  = rdy[1];
  assign out_word.valid = v_r[NST];
  assign out_word.hit   = hit;

`ifndef SYNTH
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_word.valid)
    else $error("result valid straight after reset");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> v_r[1])
    else $error("accepted word did not enter first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] && !rdy[4] |=> v_r[4])
    else $error("stalled word lost in classify stage");
`endif

endmodule
